FILE: design/hfii_pkg.sv
`default_nettype none

package hfii_pkg;

  // Image geometry
  localparam int ImageWidth  = 128;
  localparam int ImageHeight = 128;

  // Field and datapath widths
  localparam int PixelW  = 8;
  localparam int FieldW  = 7;
  localparam int TypeW   = 3;
  localparam int EntryW  = 23;
  localparam int ColSumW = 15;
  localparam int ValueW  = 23;
  localparam int WeightW = 4;

  localparam int XW    = $clog2(ImageWidth);
  localparam int YW    = $clog2(ImageHeight);
  localparam int AddrW = $clog2(ImageWidth * ImageHeight);

  // Corner coordinates before the fit check: up to origin + 3 * size, and
  // wide enough to compare against the image size itself
  localparam int CoordMinW = FieldW + 2;
  localparam int CoordXW   = (XW + 1 > CoordMinW) ? XW + 1 : CoordMinW;
  localparam int CoordW    = (YW + 1 > CoordXW) ? YW + 1 : CoordXW;

  typedef enum logic {
    KIND_LOAD  = 1'b0,
    KIND_QUERY = 1'b1
  } kind_e;

  typedef enum logic [TypeW-1:0] {
    FT_STACK_TOP_NEG = 3'd0,
    FT_STACK_TOP_POS = 3'd1,
    FT_SIDE_LEFT_NEG = 3'd2,
    FT_SIDE_LEFT_POS = 3'd3,
    FT_THREE_ACROSS  = 3'd4,
    FT_THREE_STACKED = 3'd5,
    FT_QUAD_DIAG     = 3'd6,
    FT_QUAD_ANTI     = 3'd7
  } feat_e;

  typedef enum logic [3:0] {
    Q_IDLE  = 4'b0001,
    Q_READ  = 4'b0010,
    Q_DRAIN = 4'b0100,
    Q_DONE  = 4'b1000
  } qstate_e;

  // One access to the integral store
  typedef struct packed {
    logic              we;
    logic [AddrW-1:0]  addr;
    logic [EntryW-1:0] wdata;
  } store_req_t;

  // Finished query held by the query unit
  typedef struct packed {
    logic                     done;
    logic                     fits;
    logic signed [ValueW-1:0] value;
  } query_res_t;

  // Rectangles across the feature
  function automatic logic [1:0] h_count(feat_e t);
    logic [1:0] n;
    unique case (t)
      FT_STACK_TOP_NEG, FT_STACK_TOP_POS, FT_THREE_STACKED: n = 2'd1;
      FT_THREE_ACROSS:                                      n = 2'd3;
      default:                                              n = 2'd2;
    endcase
    return n;
  endfunction

  // Rectangles down the feature
  function automatic logic [1:0] v_count(feat_e t);
    logic [1:0] n;
    unique case (t)
      FT_SIDE_LEFT_NEG, FT_SIDE_LEFT_POS, FT_THREE_ACROSS: n = 2'd1;
      FT_THREE_STACKED:                                    n = 2'd3;
      default:                                             n = 2'd2;
    endcase
    return n;
  endfunction

  // Sign of the sub-rectangle at column ri, row rj; zero outside the feature
  function automatic logic signed [2:0] rect_sign(feat_e t, logic [1:0] ri, logic [1:0] rj);
    logic signed [2:0] s;
    logic              tl, tr, bl, bm, mr;
    tl = (ri == 2'd0) && (rj == 2'd0);
    tr = (ri == 2'd1) && (rj == 2'd0);
    bl = (ri == 2'd0) && (rj == 2'd1);
    bm = (ri == 2'd1) && (rj == 2'd1);
    mr = (ri == 2'd2) && (rj == 2'd0);
    s  = 3'sd0;
    unique case (t)
      FT_STACK_TOP_NEG: begin
        if (tl) s = -3'sd1;
        else if (bl) s = 3'sd1;
      end
      FT_STACK_TOP_POS: begin
        if (tl) s = 3'sd1;
        else if (bl) s = -3'sd1;
      end
      FT_SIDE_LEFT_NEG: begin
        if (tl) s = -3'sd1;
        else if (tr) s = 3'sd1;
      end
      FT_SIDE_LEFT_POS: begin
        if (tl) s = 3'sd1;
        else if (tr) s = -3'sd1;
      end
      FT_THREE_ACROSS: begin
        if (tl || mr) s = 3'sd1;
        else if (tr) s = -3'sd1;
      end
      FT_THREE_STACKED: begin
        if (tl || ((ri == 2'd0) && (rj == 2'd2))) s = 3'sd1;
        else if (bl) s = -3'sd1;
      end
      FT_QUAD_DIAG: begin
        if (tl || bm) s = 3'sd1;
        else if (tr || bl) s = -3'sd1;
      end
      FT_QUAD_ANTI: begin
        if (tl || bm) s = -3'sd1;
        else if (tr || bl) s = 3'sd1;
      end
      default: s = 3'sd0;
    endcase
    return s;
  endfunction

  // Weight of grid corner (i, j) in the sum over all rectangles
  function automatic logic signed [WeightW-1:0] corner_weight(feat_e t, logic [1:0] i,
                                                               logic [1:0] j);
    logic signed [2:0]         s;
    logic signed [WeightW-1:0] w;
    s = rect_sign(t, i, j);
    w = $signed({s[2], s});
    if ((i != 2'd0) && (j != 2'd0)) begin
      s = rect_sign(t, i - 2'd1, j - 2'd1);
      w = w + $signed({s[2], s});
    end
    if (i != 2'd0) begin
      s = rect_sign(t, i - 2'd1, j);
      w = w - $signed({s[2], s});
    end
    if (j != 2'd0) begin
      s = rect_sign(t, i, j - 2'd1);
      w = w - $signed({s[2], s});
    end
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: design/hfii_if.sv
`default_nettype none

// Input channel: pixel loads and feature queries
interface hfii_in_if import hfii_pkg::*;;
  logic              valid;
  logic              ready;
  logic              kind;
  logic              start_of_image;
  logic [PixelW-1:0] pixel;
  logic [TypeW-1:0]  feature_type;
  logic [FieldW-1:0] origin_x;
  logic [FieldW-1:0] origin_y;
  logic [FieldW-1:0] rect_width;
  logic [FieldW-1:0] rect_height;

  modport source (
    output valid, kind, start_of_image, pixel, feature_type,
           origin_x, origin_y, rect_width, rect_height,
    input  ready
  );
  modport sink (
    input  valid, kind, start_of_image, pixel, feature_type,
           origin_x, origin_y, rect_width, rect_height,
    output ready
  );
endinterface

// Result channel: one item per query
interface hfii_out_if import hfii_pkg::*;;
  logic                     valid;
  logic                     ready;
  logic signed [ValueW-1:0] feature_value;
  logic                     fits;

  modport source (
    output valid, feature_value, fits,
    input  ready
  );
  modport sink (
    input  valid, feature_value, fits,
    output ready
  );
endinterface

`default_nettype wire

FILE: design/hfii_ram.sv
`default_nettype none

module hfii_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] addr_i,
  input  wire logic [Width-1:0]         wdata_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  // Write on we, register the read data every cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_q <= mem[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: design/hfii_loader.sv
`default_nettype none

module hfii_loader import hfii_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic              sof_i,
  input  wire logic [PixelW-1:0] pixel_i,
  output logic                   busy_o,
  output store_req_t             req_o
);

  logic               busy_q, busy_d;
  logic [XW-1:0]      col_q, col_d;
  logic [YW-1:0]      row_q, row_d;
  logic [AddrW-1:0]   addr_q, addr_d;
  logic [EntryW-1:0]  rowsum_q, rowsum_d;
  logic [XW-1:0]      cur_col_q, cur_col_d;
  logic [YW-1:0]      cur_row_q, cur_row_d;
  logic [AddrW-1:0]   cur_addr_q, cur_addr_d;
  logic [PixelW-1:0]  pix_q, pix_d;
  logic [ColSumW-1:0] colsum_rdata;
  logic [ColSumW-1:0] cs;
  logic [XW-1:0]      colsum_addr;

  // Column sums: read at accept, written back in the following cycle
  hfii_ram #(
    .Width (ColSumW),
    .Depth (ImageWidth)
  ) u_colsum (
    .clk_i   (clk_i),
    .we_i    (busy_q),
    .addr_i  (colsum_addr),
    .wdata_i (cs),
    .rdata_o (colsum_rdata)
  );

  // New column sum; the top row starts fresh
  assign cs = (cur_row_q == '0) ? ColSumW'(pix_q) : colsum_rdata + ColSumW'(pix_q);

  always_comb begin
    busy_d     = busy_q;
    col_d      = col_q;
    row_d      = row_q;
    addr_d     = addr_q;
    rowsum_d   = rowsum_q;
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    cur_addr_d = cur_addr_q;
    pix_d      = pix_q;

    colsum_addr = busy_q ? cur_col_q : (sof_i ? '0 : col_q);

    if (busy_q) begin
      // Add into the row sum and advance the raster position
      busy_d   = 1'b0;
      rowsum_d = (cur_col_q == '0) ? EntryW'(cs) : rowsum_q + EntryW'(cs);
      if (cur_col_q == XW'(ImageWidth - 1)) begin
        col_d = '0;
        row_d = (cur_row_q == YW'(ImageHeight - 1)) ? '0 : cur_row_q + 1'b1;
      end else begin
        col_d = cur_col_q + 1'b1;
        row_d = cur_row_q;
      end
      addr_d = (cur_addr_q == AddrW'(ImageWidth * ImageHeight - 1)) ? '0
                                                                    : cur_addr_q + 1'b1;
    end else if (start_i) begin
      // Capture the pixel and its position
      busy_d     = 1'b1;
      cur_col_d  = sof_i ? '0 : col_q;
      cur_row_d  = sof_i ? '0 : row_q;
      cur_addr_d = sof_i ? '0 : addr_q;
      pix_d      = pixel_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      col_q    <= '0;
      row_q    <= '0;
      addr_q   <= '0;
      rowsum_q <= '0;
    end else begin
      busy_q   <= busy_d;
      col_q    <= col_d;
      row_q    <= row_d;
      addr_q   <= addr_d;
      rowsum_q <= rowsum_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_col_q  <= cur_col_d;
    cur_row_q  <= cur_row_d;
    cur_addr_q <= cur_addr_d;
    pix_q      <= pix_d;
  end

  assign busy_o      = busy_q;
  assign req_o.we    = busy_q;
  assign req_o.addr  = cur_addr_q;
  assign req_o.wdata = rowsum_d;

endmodule

`default_nettype wire

FILE: design/hfii_query.sv
`default_nettype none

module hfii_query import hfii_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              start_i,
  input  wire logic [TypeW-1:0]  feature_type_i,
  input  wire logic [FieldW-1:0] origin_x_i,
  input  wire logic [FieldW-1:0] origin_y_i,
  input  wire logic [FieldW-1:0] rect_width_i,
  input  wire logic [FieldW-1:0] rect_height_i,
  input  wire logic              take_i,
  output logic                   idle_o,
  output store_req_t             req_o,
  input  wire logic [EntryW-1:0] rdata_i,
  output query_res_t             res_o
);

  qstate_e                    state_q, state_d;
  feat_e                      type_q, type_d;
  feat_e                      type_in;
  logic [1:0]                 hf_q, hf_d, vf_q, vf_d;
  logic [1:0]                 hf_in, vf_in;
  logic [1:0]                 i_q, i_d, j_q, j_d;
  logic [XW-1:0]              xs_q [4];
  logic [XW-1:0]              xs_d [4];
  logic [YW-1:0]              ys_q [4];
  logic [YW-1:0]              ys_d [4];
  logic [CoordW-1:0]          xs_w [4];
  logic [CoordW-1:0]          ys_w [4];
  logic                       fits_in;
  logic                       fits_q, fits_d;
  logic [EntryW-1:0]          acc_q, acc_d;
  logic signed [WeightW-1:0]  w_q, w_d;
  logic                       rd_pend_q, rd_pend_d;
  logic signed [EntryW+4:0]   prod;
  logic                       last_pt;

  // Grid corner coordinates and fit check of a new query
  assign type_in = feat_e'(feature_type_i);
  assign hf_in   = h_count(type_in);
  assign vf_in   = v_count(type_in);

  always_comb begin
    xs_w[0] = CoordW'(origin_x_i);
    ys_w[0] = CoordW'(origin_y_i);
    for (int k = 1; k < 4; k++) begin
      xs_w[k] = xs_w[k-1] + CoordW'(rect_width_i);
      ys_w[k] = ys_w[k-1] + CoordW'(rect_height_i);
    end
  end

  assign fits_in = (xs_w[hf_in] < CoordW'(ImageWidth)) && (ys_w[vf_in] < CoordW'(ImageHeight));

  // Weighted entry of the corner read last cycle
  assign prod    = $signed({1'b0, rdata_i}) * w_q;
  assign last_pt = (i_q == hf_q) && (j_q == vf_q);

  always_comb begin
    state_d   = state_q;
    type_d    = type_q;
    hf_d      = hf_q;
    vf_d      = vf_q;
    i_d       = i_q;
    j_d       = j_q;
    xs_d      = xs_q;
    ys_d      = ys_q;
    fits_d    = fits_q;
    acc_d     = acc_q;
    w_d       = w_q;
    rd_pend_d = (state_q == Q_READ);

    if (rd_pend_q) begin
      acc_d = acc_q + prod[EntryW-1:0];
    end

    unique case (state_q)
      Q_IDLE: begin
        if (start_i) begin
          type_d = type_in;
          hf_d   = hf_in;
          vf_d   = vf_in;
          i_d    = '0;
          j_d    = '0;
          fits_d = fits_in;
          acc_d  = '0;
          for (int k = 0; k < 4; k++) begin
            xs_d[k] = xs_w[k][XW-1:0];
            ys_d[k] = ys_w[k][YW-1:0];
          end
          state_d = fits_in ? Q_READ : Q_DONE;
        end
      end
      Q_READ: begin
        // Issue one corner read, step across then down the grid
        w_d = corner_weight(type_q, i_q, j_q);
        if (i_q == hf_q) begin
          i_d = '0;
          j_d = j_q + 2'd1;
        end else begin
          i_d = i_q + 2'd1;
        end
        if (last_pt) begin
          state_d = Q_DRAIN;
        end
      end
      Q_DRAIN: begin
        state_d = Q_DONE;
      end
      Q_DONE: begin
        if (take_i) begin
          state_d = Q_IDLE;
        end
      end
      default: state_d = Q_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= Q_IDLE;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      rd_pend_q <= rd_pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    type_q <= type_d;
    hf_q   <= hf_d;
    vf_q   <= vf_d;
    i_q    <= i_d;
    j_q    <= j_d;
    xs_q   <= xs_d;
    ys_q   <= ys_d;
    fits_q <= fits_d;
    acc_q  <= acc_d;
    w_q    <= w_d;
  end

  assign idle_o      = (state_q == Q_IDLE);
  assign req_o.we    = 1'b0;
  assign req_o.addr  = AddrW'(ys_q[j_q]) * AddrW'(ImageWidth) + AddrW'(xs_q[i_q]);
  assign req_o.wdata = '0;
  assign res_o.done  = (state_q == Q_DONE);
  assign res_o.fits  = fits_q;
  assign res_o.value = fits_q ? $signed(acc_q) : '0;

endmodule

`default_nettype wire

FILE: design/haar_feature_integral_image.sv
// Pixel load: stored in the cycle after accept; no new item is accepted during that write.
// Query that fits: one store read per grid corner (6, 8 or 9 corners through the single port),
// result built in the read and drain states; next item accepted once the query unit is idle again.
// Query that does not fit: result registered in the cycle after accept, no store reads.
// A full output register holds a finished query in its done state until the slot frees.
// Reset clears the load position, row sum and handshake state; stores hold garbage until written.
`default_nettype none

module haar_feature_integral_image import hfii_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  hfii_in_if.sink   in_i,
  hfii_out_if.source out_o
);

  logic                     accept;
  logic                     load_start;
  logic                     query_start;
  logic                     load_busy;
  logic                     query_idle;
  logic                     take;
  store_req_t               ld_req;
  store_req_t               q_req;
  store_req_t               st_req;
  logic [EntryW-1:0]        st_rdata;
  query_res_t               res;
  logic                     out_valid_q, out_valid_d;
  logic signed [ValueW-1:0] out_value_q;
  logic                     out_fits_q;

  // Take a new item only when both units are free
  assign in_i.ready  = !load_busy && query_idle;
  assign accept      = in_i.valid && in_i.ready;
  assign load_start  = accept && (in_i.kind == KIND_LOAD);
  assign query_start = accept && (in_i.kind == KIND_QUERY);

  hfii_loader u_loader (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (load_start),
    .sof_i   (in_i.start_of_image),
    .pixel_i (in_i.pixel),
    .busy_o  (load_busy),
    .req_o   (ld_req)
  );

  hfii_query u_query (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (query_start),
    .feature_type_i (in_i.feature_type),
    .origin_x_i     (in_i.origin_x),
    .origin_y_i     (in_i.origin_y),
    .rect_width_i   (in_i.rect_width),
    .rect_height_i  (in_i.rect_height),
    .take_i         (take),
    .idle_o         (query_idle),
    .req_o          (q_req),
    .rdata_i        (st_rdata),
    .res_o          (res)
  );

  // Share the store port: loads write, queries read, never in the same cycle
  assign st_req = ld_req.we ? ld_req : q_req;

  hfii_ram #(
    .Width (EntryW),
    .Depth (ImageWidth * ImageHeight)
  ) u_integral (
    .clk_i   (clk_i),
    .we_i    (st_req.we),
    .addr_i  (st_req.addr),
    .wdata_i (st_req.wdata),
    .rdata_o (st_rdata)
  );

  // Output register: move a finished result in once the slot is free
  assign take = res.done && (!out_valid_q || out_o.ready);

  always_comb begin
    out_valid_d = out_valid_q;
    if (take) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_value_q <= res.value;
      out_fits_q  <= res.fits;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.feature_value = out_value_q;
  assign out_o.fits          = out_fits_q;

endmodule

`default_nettype wire
